/* sv/tmbp_pkg.sv */
// shared types and constants for the tagged message byte parser
package tmbp_pkg;

  localparam int ByteW  = 8;
  localparam int WordW  = 32;
  localparam int AccW   = 24;
  localparam int KindW  = 4;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INT_TAG         = 3'd0,
    CFG_FLOAT_TAG       = 3'd1,
    CFG_STRING_TAG      = 3'd2,
    CFG_OBJECT_TAG      = 3'd3,
    CFG_STRING_END_TAG  = 3'd4,
    CFG_MESSAGE_END_TAG = 3'd5
  } cfg_index_t;

  localparam logic [ByteW-1:0] IntTagReset        = 8'd1;
  localparam logic [ByteW-1:0] FloatTagReset      = 8'd2;
  localparam logic [ByteW-1:0] StringTagReset     = 8'd3;
  localparam logic [ByteW-1:0] ObjectTagReset     = 8'd4;
  localparam logic [ByteW-1:0] StringEndTagReset  = 8'd5;
  localparam logic [ByteW-1:0] MessageEndTagReset = 8'd6;

  typedef struct packed {
    logic [ByteW-1:0] int_tag;
    logic [ByteW-1:0] float_tag;
    logic [ByteW-1:0] string_tag;
    logic [ByteW-1:0] object_tag;
    logic [ByteW-1:0] string_end_tag;
    logic [ByteW-1:0] message_end_tag;
  } tags_t;

  typedef enum logic [KindW-1:0] {
    TOK_TARGET   = 4'd0,
    TOK_SEL_BYTE = 4'd1,
    TOK_SEL_END  = 4'd2,
    TOK_INT      = 4'd3,
    TOK_FLOAT    = 4'd4,
    TOK_STR_BYTE = 4'd5,
    TOK_STR_END  = 4'd6,
    TOK_OBJECT   = 4'd7,
    TOK_MSG_END  = 4'd8,
    TOK_ERROR    = 4'd9
  } token_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TARGET,
    ST_SEL_TAG,
    ST_SEL,
    ST_ARGS,
    ST_WORD,
    ST_STR
  } parse_state_t;

  typedef struct packed {
    logic        emit;
    token_kind_t kind;
    logic [WordW-1:0] value;
  } token_t;

endpackage

/* sv/tmbp_tag_regs.sv */
// tag byte configuration registers
module tmbp_tag_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tmbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tmbp_pkg::ByteW-1:0]    cfg_data,
  output tmbp_pkg::tags_t               tags
);
  import tmbp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      tags.int_tag         <= IntTagReset;
      tags.float_tag       <= FloatTagReset;
      tags.string_tag      <= StringTagReset;
      tags.object_tag      <= ObjectTagReset;
      tags.string_end_tag  <= StringEndTagReset;
      tags.message_end_tag <= MessageEndTagReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INT_TAG:         tags.int_tag         <= cfg_data;
        CFG_FLOAT_TAG:       tags.float_tag       <= cfg_data;
        CFG_STRING_TAG:      tags.string_tag      <= cfg_data;
        CFG_OBJECT_TAG:      tags.object_tag      <= cfg_data;
        CFG_STRING_END_TAG:  tags.string_end_tag  <= cfg_data;
        CFG_MESSAGE_END_TAG: tags.message_end_tag <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/tmbp_parser.sv */
// message parse state machine and word assembly
module tmbp_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [tmbp_pkg::ByteW-1:0]  data_byte,
  input  tmbp_pkg::tags_t             tags,
  output tmbp_pkg::token_t            token
);
  import tmbp_pkg::*;

  parse_state_t      state, state_next;
  logic [1:0]        pos, pos_next;
  logic [AccW-1:0]   acc, acc_next;
  token_kind_t       word_kind, word_kind_next;

  logic [WordW-1:0]  byte_ext;
  logic [WordW-1:0]  word_full;

  assign byte_ext  = {{(WordW-ByteW){1'b0}}, data_byte};
  assign word_full = {acc, data_byte};

  // next state, byte position and accumulator
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    acc_next       = acc;
    word_kind_next = word_kind;
    unique case (state)
      ST_IDLE: begin
        if (data_byte == tags.object_tag) begin
          state_next = ST_TARGET;
          pos_next   = 2'd0;
          acc_next   = '0;
        end
      end
      ST_TARGET, ST_WORD: begin
        if (pos != 2'd3) begin
          acc_next = {acc[AccW-ByteW-1:0], data_byte};
          pos_next = pos + 2'd1;
        end else begin
          state_next = (state == ST_TARGET) ? ST_SEL_TAG : ST_ARGS;
        end
      end
      ST_SEL_TAG: begin
        state_next = (data_byte == tags.string_tag) ? ST_SEL : ST_IDLE;
      end
      ST_SEL, ST_STR: begin
        if (data_byte == tags.string_end_tag) state_next = ST_ARGS;
      end
      ST_ARGS: begin
        pos_next = 2'd0;
        acc_next = '0;
        if (data_byte == tags.int_tag) begin
          state_next     = ST_WORD;
          word_kind_next = TOK_INT;
        end else if (data_byte == tags.float_tag) begin
          state_next     = ST_WORD;
          word_kind_next = TOK_FLOAT;
        end else if (data_byte == tags.string_tag) begin
          state_next = ST_STR;
        end else if (data_byte == tags.object_tag) begin
          state_next     = ST_WORD;
          word_kind_next = TOK_OBJECT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // token for the current byte
  always_comb begin
    token.emit  = 1'b0;
    token.kind  = TOK_ERROR;
    token.value = '0;
    unique case (state)
      ST_IDLE: begin
        token.emit = (data_byte != tags.object_tag);
      end
      ST_TARGET, ST_WORD: begin
        token.emit  = (pos == 2'd3);
        token.kind  = (state == ST_TARGET) ? TOK_TARGET : word_kind;
        token.value = word_full;
      end
      ST_SEL_TAG: begin
        token.emit = (data_byte != tags.string_tag);
      end
      ST_SEL, ST_STR: begin
        token.emit = 1'b1;
        if (data_byte == tags.string_end_tag) begin
          token.kind = (state == ST_SEL) ? TOK_SEL_END : TOK_STR_END;
        end else begin
          token.kind  = (state == ST_SEL) ? TOK_SEL_BYTE : TOK_STR_BYTE;
          token.value = byte_ext;
        end
      end
      ST_ARGS: begin
        // type tags are silent, message end or anything else emits
        if (data_byte != tags.int_tag && data_byte != tags.float_tag &&
            data_byte != tags.string_tag && data_byte != tags.object_tag) begin
          token.emit = 1'b1;
          token.kind = (data_byte == tags.message_end_tag) ? TOK_MSG_END : TOK_ERROR;
        end
      end
      default: token.emit = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= 2'd0;
      acc       <= '0;
      word_kind <= TOK_INT;
    end else if (step) begin
      state     <= state_next;
      pos       <= pos_next;
      acc       <= acc_next;
      word_kind <= word_kind_next;
    end
  end

endmodule

/* sv/tagged_message_byte_parser_top.sv */
// top level: input byte register, parser and output token register
//
// Bytes of a tagged message stream enter on the s_ channel, one word per
// byte; tokens leave on the m_ channel with the kind in m_tuser and the
// value in m_tdata. Tag bytes (object, selector string tag, argument type
// tags) and the first three bytes of each 4-byte word produce no token;
// every other byte produces exactly one.
// An accepted byte sits in the input register; the parse logic writes its
// token into the output register when the pipe advances, so the token is
// registered and is held there until the receiver takes it.
// Throughput is one byte per cycle while m_tready is high; the rate is set
// by the combinational tag compare and shift of the parse state machine.
// When the receiver stalls with a token held, both registers hold and
// s_tready drops once the input register is also full; a free output slot
// or a taken token lets the pipe advance in the same cycle.
// Tag values are written on the cfg_ port (index 0..5: int, float, string,
// object, string end, message end) and apply from the next parsed byte.
// Synchronous reset empties both registers, returns the parser to idle
// (waiting for the object tag) and restores the default tag values 1..6.
module tagged_message_byte_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tmbp_pkg::ByteW-1:0]    s_tdata,   // [7:0] data_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tmbp_pkg::WordW-1:0]    m_tdata,   // [31:0] token_value
  output logic [tmbp_pkg::KindW-1:0]    m_tuser,   // [3:0] token_kind
  input  logic                          cfg_we,
  input  logic [tmbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tmbp_pkg::ByteW-1:0]    cfg_data
);
  import tmbp_pkg::*;

  tags_t             tags;
  token_t            token;
  logic              in_valid;
  logic [ByteW-1:0]  in_byte;
  logic              advance;
  logic              step;

  // the pipe moves whenever the output slot is free or being emptied
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  tmbp_tag_regs u_tag_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tags      (tags)
  );

  tmbp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .tags      (tags),
    .token     (token)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && token.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && token.emit) begin
      m_tdata <= token.value;
      m_tuser <= token.kind;
    end
  end

endmodule

/* test/tb_tagged_message_byte_parser_top.sv */
// testbench for the tagged message byte parser: message streams checked token by token
`timescale 1ns / 100ps

module tb_tagged_message_byte_parser_top;
  import tmbp_pkg::*;

  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 11;
  localparam int Latency     = 2;
  localparam int MaxGap      = 18;
  localparam int StallLimit  = 1000;
  localparam int NumPhases   = 6;
  localparam int PhaseBytes  = 187;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    token_kind_t      kind;
    logic [WordW-1:0] value;
  } tok_t;

  class token_scoreboard;
    tags_t            tags;
    parse_state_t     state;
    token_kind_t      word_kind;
    int unsigned      word_pos;
    logic [AccW-1:0]  acc;
    tok_t             pending_q[$];
    int unsigned      bytes_in;
    int unsigned      tokens_ok;
    int unsigned      errors;
    int unsigned      kind_hits[10];

    function new();
      tags = '{IntTagReset, FloatTagReset, StringTagReset, ObjectTagReset,
               StringEndTagReset, MessageEndTagReset};
      state = ST_IDLE;
      word_kind = TOK_TARGET;
      word_pos = 0;
      acc = '0;
    endfunction

    function void set_tag(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        CFG_INT_TAG:         tags.int_tag = val;
        CFG_FLOAT_TAG:       tags.float_tag = val;
        CFG_STRING_TAG:      tags.string_tag = val;
        CFG_OBJECT_TAG:      tags.object_tag = val;
        CFG_STRING_END_TAG:  tags.string_end_tag = val;
        CFG_MESSAGE_END_TAG: tags.message_end_tag = val;
        default: ;
      endcase
    endfunction

    function void add_token(token_kind_t kind, logic [WordW-1:0] value);
      pending_q.push_back('{kind, value});
    endfunction

    // parse one accepted byte and queue the token it should produce
    function void note_byte(logic [ByteW-1:0] b);
      bytes_in++;
      case (state)
        ST_IDLE: begin
          if (b == tags.object_tag) begin
            state = ST_TARGET;
            word_kind = TOK_TARGET;
            word_pos = 0;
            acc = '0;
          end else begin
            add_token(TOK_ERROR, '0);
          end
        end
        ST_TARGET, ST_WORD: begin
          if (word_pos < 3) begin
            acc = {acc[AccW-ByteW-1:0], b};
            word_pos++;
          end else begin
            add_token(word_kind, {acc, b});
            state = (state == ST_TARGET) ? ST_SEL_TAG : ST_ARGS;
          end
        end
        ST_SEL_TAG: begin
          if (b == tags.string_tag) begin
            state = ST_SEL;
          end else begin
            state = ST_IDLE;
            add_token(TOK_ERROR, '0);
          end
        end
        ST_SEL: begin
          if (b == tags.string_end_tag) begin
            state = ST_ARGS;
            add_token(TOK_SEL_END, '0);
          end else begin
            add_token(TOK_SEL_BYTE, {24'd0, b});
          end
        end
        ST_ARGS: begin
          acc = '0;
          word_pos = 0;
          // first matching tag wins when several tags share a value
          if (b == tags.int_tag) begin
            state = ST_WORD;
            word_kind = TOK_INT;
          end else if (b == tags.float_tag) begin
            state = ST_WORD;
            word_kind = TOK_FLOAT;
          end else if (b == tags.string_tag) begin
            state = ST_STR;
          end else if (b == tags.object_tag) begin
            state = ST_WORD;
            word_kind = TOK_OBJECT;
          end else begin
            state = ST_IDLE;
            add_token((b == tags.message_end_tag) ? TOK_MSG_END : TOK_ERROR, '0);
          end
        end
        ST_STR: begin
          if (b == tags.string_end_tag) begin
            state = ST_ARGS;
            add_token(TOK_STR_END, '0);
          end else begin
            add_token(TOK_STR_BYTE, {24'd0, b});
          end
        end
        default: begin
          state = ST_IDLE;
          add_token(TOK_ERROR, '0);
        end
      endcase
    endfunction

    function void check_token(logic [KindW-1:0] kind, logic [WordW-1:0] value);
      tok_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none, actual kind %0d value %h",
                 $time, kind, value);
        return;
      end
      want = pending_q.pop_front();
      if (kind !== want.kind) begin
        errors++;
        $display("%0t: token kind: expected %0d, actual %0d", $time, want.kind, kind);
      end
      if (value !== want.value) begin
        errors++;
        $display("%0t: token value (kind %0d): expected %h, actual %h",
                 $time, want.kind, want.value, value);
      end
      if (kind === want.kind && value === want.value) begin
        tokens_ok++;
        kind_hits[want.kind]++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [WordW-1:0]    m_tdata;
  logic [KindW-1:0]    m_tuser;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [ByteW-1:0]    cfg_data;

  token_scoreboard     sb = new();
  tags_t               cur_tags = '{IntTagReset, FloatTagReset, StringTagReset,
                                    ObjectTagReset, StringEndTagReset, MessageEndTagReset};
  logic [ByteW-1:0]    burst_q[$];
  bit                  src_idle = 1'b1;
  bit                  sink_idle = 1'b1;
  int                  sink_hold = 0;
  int                  quiet = 0;
  int                  settings_used = 1;

  tagged_message_byte_parser_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_token(m_tuser, m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // token receiver: random stalls, plus a long hold-off when asked
  initial begin : token_sink
    int gap;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, MaxGap) : 0;
      if (sink_hold > 0) begin
        gap = sink_hold;
        sink_hold = 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic send_burst();
    foreach (burst_q[i]) send_byte(burst_q[i]);
    burst_q.delete();
  endtask

  // drain everything in flight, including bytes that make no token
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
  endtask

  task automatic load_tags(input tags_t t);
    cfg_index_t       regs[6];
    logic [ByteW-1:0] vals[6];
    regs = '{CFG_INT_TAG, CFG_FLOAT_TAG, CFG_STRING_TAG, CFG_OBJECT_TAG,
             CFG_STRING_END_TAG, CFG_MESSAGE_END_TAG};
    vals = '{t.int_tag, t.float_tag, t.string_tag, t.object_tag,
             t.string_end_tag, t.message_end_tag};
    foreach (regs[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      sb.set_tag(regs[i], vals[i]);
      @(negedge clk);
    end
    // spare index, must leave every tag alone
    cfg_index <= $urandom_range(0, 1) ? CfgSpareHi : CfgSpareLo;
    cfg_data <= 8'($urandom_range(0, 255));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_tags = t;
    settings_used++;
  endtask

  function automatic tags_t pick_tags(int phase);
    tags_t            t;
    logic [ByteW-1:0] base;
    logic [ByteW-1:0] step;
    case (phase)
      1: t = '{default: 8'h00};
      2: t = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
      3: t = '{8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
               8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)), 8'($urandom_range(0, 2))};
      4: t = '{default: 8'hFF};
      default: begin
        // six distinct values
        base = 8'($urandom_range(0, 255));
        step = 8'($urandom_range(1, 42));
        t = '{base, 8'(base + step), 8'(base + 2 * step), 8'(base + 3 * step),
              8'(base + 4 * step), 8'(base + 5 * step)};
      end
    endcase
    return t;
  endfunction

  function automatic logic [ByteW-1:0] any_tag();
    case ($urandom_range(0, 5))
      0: return cur_tags.int_tag;
      1: return cur_tags.float_tag;
      2: return cur_tags.string_tag;
      3: return cur_tags.object_tag;
      4: return cur_tags.string_end_tag;
      default: return cur_tags.message_end_tag;
    endcase
  endfunction

  // payload byte, now and then equal to a tag
  function automatic logic [ByteW-1:0] payload_byte();
    return ($urandom_range(0, 3) == 0) ? any_tag() : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [ByteW-1:0] text_byte();
    logic [ByteW-1:0] b;
    do b = payload_byte(); while (b == cur_tags.string_end_tag);
    return b;
  endfunction

  task automatic add_word(input logic [ByteW-1:0] tag);
    burst_q.push_back(tag);
    repeat (4) burst_q.push_back(payload_byte());
  endtask

  task automatic add_text(input int len);
    burst_q.push_back(cur_tags.string_tag);
    repeat (len) burst_q.push_back(text_byte());
    burst_q.push_back(cur_tags.string_end_tag);
  endtask

  task automatic build_message();
    int nargs;
    burst_q.push_back(cur_tags.object_tag);
    repeat (4) burst_q.push_back(payload_byte());
    add_text(($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4));
    nargs = $urandom_range(0, 5);
    repeat (nargs) begin
      case ($urandom_range(0, 3))
        0: add_word(cur_tags.int_tag);
        1: add_word(cur_tags.float_tag);
        2: add_word(cur_tags.object_tag);
        default: add_text($urandom_range(0, 6));
      endcase
    end
    burst_q.push_back(cur_tags.message_end_tag);
  endtask

  // cut the message short and follow with a stray byte
  task automatic break_message();
    int keep;
    keep = $urandom_range(1, burst_q.size() - 1);
    while (burst_q.size() > keep) void'(burst_q.pop_back());
    burst_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int unsigned goal;
    int          pick;
    bit          first;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (ResetCycles) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one message with every argument kind and extreme words, then a stray byte in idle
    burst_q = '{cur_tags.object_tag, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                cur_tags.string_tag, 8'h00, cur_tags.string_end_tag,
                cur_tags.int_tag, cur_tags.message_end_tag, cur_tags.string_end_tag,
                cur_tags.object_tag, cur_tags.string_tag,
                cur_tags.float_tag, 8'h00, 8'h00, 8'h00, 8'h00,
                cur_tags.string_tag, 8'hFF, cur_tags.string_end_tag,
                cur_tags.object_tag, 8'h80, 8'h00, 8'h00, 8'h01,
                cur_tags.message_end_tag, 8'h00};
    send_burst();

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      load_tags(pick_tags(phase));
      goal = sb.bytes_in + PhaseBytes;
      first = 1'b1;
      while (sb.bytes_in < goal) begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        if (first && (phase == 0 || phase == 3)) begin
          // receiver holds off while bytes keep coming
          sink_hold = $urandom_range(60, 100);
          src_idle = 1'b0;
        end
        first = 1'b0;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          build_message();
        end else if (pick < 9) begin
          build_message();
          break_message();
        end else begin
          repeat ($urandom_range(1, 6)) burst_q.push_back(payload_byte());
        end
        send_burst();
      end
    end

    settle();
    $display("run: %0d bytes under %0d tag settings, %0d tokens matched",
             sb.bytes_in, settings_used, sb.tokens_ok);
    $display("run: %0d message ends, %0d error tokens, %0d words, %0d text bytes",
             sb.kind_hits[TOK_MSG_END], sb.kind_hits[TOK_ERROR],
             sb.kind_hits[TOK_TARGET] + sb.kind_hits[TOK_INT] + sb.kind_hits[TOK_FLOAT] +
             sb.kind_hits[TOK_OBJECT],
             sb.kind_hits[TOK_SEL_BYTE] + sb.kind_hits[TOK_STR_BYTE]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
